// ----- rtl/core/b2r_pkg.sv -----
// Shared types, header layout constants and result codes for the bitmap stream decoder.
package b2r_pkg;

   // Default limit on the padded length of one pixel row, in bytes.
   localparam int unsigned MAX_ROW_BYTES_DEF = 512;

   // Header layout: every position is a byte offset from the start of the file.
   localparam logic [31:0] HDR_BYTES      = 32'd54;
   localparam logic [31:0] HDR_LAST_POS   = 32'd53;
   localparam logic [31:0] SIG_FIRST_POS  = 32'd0;
   localparam logic [31:0] SIG_SECOND_POS = 32'd1;
   localparam logic [31:0] OFFSET_POS     = 32'd10;
   localparam logic [31:0] WIDTH_POS      = 32'd18;
   localparam logic [31:0] HEIGHT_POS     = 32'd22;
   localparam logic [31:0] DEPTH_POS      = 32'd28;

   localparam logic [7:0]  SIG_FIRST      = 8'h42;   // 'B'
   localparam logic [7:0]  SIG_SECOND     = 8'h4D;   // 'M'
   localparam logic [15:0] DEPTH_BGR888   = 16'd24;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXEL,
      PH_PAD,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      STAT_PIXEL      = 3'd0,
      STAT_BAD_SIG    = 3'd1,
      STAT_BAD_DEPTH  = 3'd2,
      STAT_ROW_WIDE   = 3'd3,
      STAT_BAD_OFFSET = 3'd4
   } status_type;

   typedef struct packed {
      logic [15:0] pixel_rgb565;
      logic [7:0]  column;
      logic [30:0] row;
      status_type  status;
      logic        last_pixel;
   } rsp_type;

endpackage

// ----- rtl/core/b2r_if.sv -----
// Valid/ready channel interfaces for the bitmap byte input and the pixel result output.
interface b2r_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_start;

   modport source (output valid, output data_byte, output file_start, input ready);
   modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface b2r_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_rgb565;
   logic [7:0]  column;
   logic [30:0] row;
   logic [2:0]  status;
   logic        last_pixel;

   modport source (output valid, output pixel_rgb565, output column, output row,
                   output status, output last_pixel, input ready);
   modport sink (input valid, input pixel_rgb565, input column, input row,
                 input status, input last_pixel, output ready);
endinterface

// ----- rtl/core/b2r_rsp_buf.sv -----
// Two-entry result buffer: an output register backed by a skid register.
module b2r_rsp_buf import b2r_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    can_take,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;

   // The skid entry only fills when the output entry is held, so a free skid
   // entry always has room for one more word.
   assign can_take  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ----- rtl/core/bmp24_to_rgb565_stream_decoder.sv -----
// Top level of the streaming 24-bit bitmap to RGB565 pixel decoder.
// This block takes a bitmap file one byte per word on the req_bus channel and
// gives one RGB565 pixel word on rsp_bus for every blue, green, red triple of
// pixel data, tagged with its column and its display row (bottom-up images are
// flipped so the top row is zero), and with last_pixel set on the final pixel.
// A word with file_start high is taken as byte 0 of a new file; after reset
// the first byte is treated as byte 0 even without file_start. The 54-byte
// header is checked: a bad signature is reported on byte 0 or 1, and once
// byte 53 is in, a depth other than 24, a padded row longer than MAX_ROW_BYTES
// and a data offset inside the header are reported in that order. An error
// gives exactly one word with a nonzero status and all other fields zero;
// then every byte is dropped until the next file_start. Row padding, bytes
// before the data offset and bytes after the last pixel give no words.
// The block takes one byte every cycle while req_bus.ready is high: all
// per-byte work sits between the parser state registers and a two-entry
// result buffer, into which a pixel word is written when its red byte is
// accepted. req_bus.ready falls only when both result buffer entries are
// full, that is when the sink has held off for two words in a row; while
// the sink takes words, the block accepts a byte in every cycle.
module bmp24_to_rgb565_stream_decoder import b2r_pkg::*; #(
   parameter int unsigned MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   b2r_req_if.sink    req_bus,
   b2r_rsp_if.source  rsp_bus
);

   // A row that fits the limit has at most MAX_ROW_BYTES / 3 pixels.
   localparam int unsigned COL_W         = $clog2(MAX_ROW_BYTES / 3 + 1);
   localparam logic [31:0] ROW_QUOT_MAX  = 32'(MAX_ROW_BYTES / 4);

   phase_type         phase_ff, phase_in;
   logic [31:0]       pos_ff, pos_in;
   logic [31:0]       offset_ff, offset_in;
   logic [31:0]       width_ff, width_in;
   logic [31:0]       raw_height_ff, raw_height_in;
   logic [31:0]       height_ff, height_in;
   logic [15:0]       depth_ff, depth_in;
   logic              rows_flip_ff, rows_flip_in;
   logic [1:0]        color_idx_ff, color_idx_in;
   logic [7:0]        blue_ff, blue_in;
   logic [7:0]        green_ff, green_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [31:0]       row_cnt_ff, row_cnt_in;
   logic [1:0]        pad_ff, pad_in;
   logic              wide_ff, wide_in;

   logic              accept;
   logic              can_take;
   logic              push;
   rsp_type           push_data;
   rsp_type           out_data;

   // Row width check, registered ahead of time: the width is complete long
   // before the last header byte. Padded length is ceil(3w/4)*4, which
   // exceeds the limit exactly when ceil(3w/4) exceeds the limit over four.
   logic [33:0]       width_x3_rnd;

   assign width_x3_rnd = {2'b00, width_ff} + {1'b0, width_ff, 1'b0} + 34'd3;
   assign wide_in      = (width_x3_rnd[33:2] > ROW_QUOT_MAX);

   assign accept        = req_bus.valid && can_take;
   assign req_bus.ready = can_take;

   always_comb begin
      phase_type         cur_phase;
      logic [31:0]       pos;
      logic [31:0]       pos_next;
      logic [1:0]        lane;
      logic [COL_W-1:0]  col_next;
      logic [31:0]       row_next;
      logic [2:0]        pad_idx_next;
      logic              last;
      logic [31:0]       disp_row;
      logic [COL_W+7:0]  col_ext;

      phase_in      = phase_ff;
      pos_in        = pos_ff;
      offset_in     = offset_ff;
      width_in      = width_ff;
      raw_height_in = raw_height_ff;
      height_in     = height_ff;
      depth_in      = depth_ff;
      rows_flip_in  = rows_flip_ff;
      color_idx_in  = color_idx_ff;
      blue_in       = blue_ff;
      green_in      = green_ff;
      col_in        = col_ff;
      row_cnt_in    = row_cnt_ff;
      pad_in        = pad_ff;
      push          = 1'b0;
      push_data     = '0;
      cur_phase     = phase_ff;
      lane          = 2'd0;
      pos           = 32'd0;
      pos_next      = 32'd0;
      col_next      = '0;
      row_next      = 32'd0;
      pad_idx_next  = 3'd0;
      last          = 1'b0;
      disp_row      = 32'd0;
      col_ext       = '0;

      if (accept) begin
         // A new file wipes all parser state before its first byte is used.
         if (req_bus.file_start) begin
            phase_in      = PH_HEADER;
            pos_in        = 32'd0;
            offset_in     = 32'd0;
            width_in      = 32'd0;
            raw_height_in = 32'd0;
            height_in     = 32'd0;
            depth_in      = 16'd0;
            rows_flip_in  = 1'b0;
            color_idx_in  = 2'd0;
            blue_in       = 8'd0;
            green_in      = 8'd0;
            col_in        = '0;
            row_cnt_in    = 32'd0;
            pad_in        = 2'd0;
         end
         cur_phase = phase_in;
         pos       = pos_in;
         pos_next  = pos + 32'd1;

         case (cur_phase)
            PH_HEADER: begin
               if ((pos == SIG_FIRST_POS && req_bus.data_byte != SIG_FIRST) ||
                   (pos == SIG_SECOND_POS && req_bus.data_byte != SIG_SECOND)) begin
                  push             = 1'b1;
                  push_data.status = STAT_BAD_SIG;
                  phase_in         = PH_ERROR;
               end else begin
                  // Little-endian fields; each byte lands in its own lane of
                  // a field that was cleared at file start.
                  if (pos >= OFFSET_POS && pos <= OFFSET_POS + 32'd3) begin
                     lane = pos[1:0] - OFFSET_POS[1:0];
                     offset_in[{lane, 3'b000} +: 8] = req_bus.data_byte;
                  end else if (pos >= WIDTH_POS && pos <= WIDTH_POS + 32'd3) begin
                     lane = pos[1:0] - WIDTH_POS[1:0];
                     width_in[{lane, 3'b000} +: 8] = req_bus.data_byte;
                  end else if (pos >= HEIGHT_POS && pos <= HEIGHT_POS + 32'd3) begin
                     lane = pos[1:0] - HEIGHT_POS[1:0];
                     raw_height_in[{lane, 3'b000} +: 8] = req_bus.data_byte;
                  end else if (pos == DEPTH_POS) begin
                     depth_in[7:0] = req_bus.data_byte;
                  end else if (pos == DEPTH_POS + 32'd1) begin
                     depth_in[15:8] = req_bus.data_byte;
                  end
                  pos_in = pos_next;

                  if (pos == HDR_LAST_POS) begin
                     if (depth_ff != DEPTH_BGR888) begin
                        push             = 1'b1;
                        push_data.status = STAT_BAD_DEPTH;
                        phase_in         = PH_ERROR;
                     end else if (wide_ff) begin
                        push             = 1'b1;
                        push_data.status = STAT_ROW_WIDE;
                        phase_in         = PH_ERROR;
                     end else if (offset_ff < HDR_BYTES) begin
                        push             = 1'b1;
                        push_data.status = STAT_BAD_OFFSET;
                        phase_in         = PH_ERROR;
                     end else begin
                        // A negative height means top-down rows; the most
                        // negative value keeps its magnitude of 2^31.
                        if (raw_height_ff[31]) begin
                           height_in    = 32'd0 - raw_height_ff;
                           rows_flip_in = 1'b0;
                        end else begin
                           height_in    = raw_height_ff;
                           rows_flip_in = (raw_height_ff != 32'd0);
                        end
                        // Pad bytes per row: (4 - 3w mod 4) mod 4, which is w mod 4.
                        pad_in = width_ff[1:0];
                        if (width_ff == 32'd0 || raw_height_ff == 32'd0) begin
                           phase_in = PH_DONE;
                        end else if (offset_ff <= HDR_BYTES) begin
                           phase_in = PH_PIXEL;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                  end
               end
            end

            PH_SKIP: begin
               pos_in = pos_next;
               if (pos_next >= offset_in) begin
                  phase_in = PH_PIXEL;
               end
            end

            PH_PIXEL: begin
               case (color_idx_in)
                  2'd0: begin
                     blue_in      = req_bus.data_byte;
                     color_idx_in = 2'd1;
                  end
                  2'd1: begin
                     green_in     = req_bus.data_byte;
                     color_idx_in = 2'd2;
                  end
                  default: begin
                     color_idx_in = 2'd0;
                     col_next     = col_in + 1'b1;
                     row_next     = row_cnt_in + 32'd1;
                     last         = (col_next == width_in[COL_W-1:0]) &&
                                    (row_next == height_in);
                     disp_row     = rows_flip_in ? (height_in - row_next) : row_cnt_in;
                     col_ext      = {8'd0, col_in};

                     push                   = 1'b1;
                     push_data.pixel_rgb565 = {req_bus.data_byte[7:3], green_in[7:2],
                                               blue_in[7:3]};
                     push_data.column       = col_ext[7:0];
                     push_data.row          = disp_row[30:0];
                     push_data.status       = STAT_PIXEL;
                     push_data.last_pixel   = last;

                     col_in = col_next;
                     if (last) begin
                        phase_in = PH_DONE;
                     end else if (col_next >= width_in[COL_W-1:0]) begin
                        if (pad_in != 2'd0) begin
                           phase_in = PH_PAD;
                        end else begin
                           col_in     = '0;
                           row_cnt_in = row_next;
                        end
                     end
                  end
               endcase
            end

            PH_PAD: begin
               pad_idx_next = {1'b0, color_idx_in} + 3'd1;
               color_idx_in = pad_idx_next[1:0];
               if (pad_idx_next >= {1'b0, pad_in}) begin
                  color_idx_in = 2'd0;
                  col_in       = '0;
                  row_cnt_in   = row_cnt_in + 32'd1;
                  phase_in     = PH_PIXEL;
               end
            end

            default: begin
               // Done or failed: bytes are dropped until the next file start.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 32'd0;
         offset_ff     <= 32'd0;
         width_ff      <= 32'd0;
         raw_height_ff <= 32'd0;
         height_ff     <= 32'd0;
         depth_ff      <= 16'd0;
         rows_flip_ff  <= 1'b0;
         color_idx_ff  <= 2'd0;
         blue_ff       <= 8'd0;
         green_ff      <= 8'd0;
         col_ff        <= '0;
         row_cnt_ff    <= 32'd0;
         pad_ff        <= 2'd0;
      end else begin
         pos_ff        <= pos_in;
         offset_ff     <= offset_in;
         width_ff      <= width_in;
         raw_height_ff <= raw_height_in;
         height_ff     <= height_in;
         depth_ff      <= depth_in;
         rows_flip_ff  <= rows_flip_in;
         color_idx_ff  <= color_idx_in;
         blue_ff       <= blue_in;
         green_ff      <= green_in;
         col_ff        <= col_in;
         row_cnt_ff    <= row_cnt_in;
         pad_ff        <= pad_in;
      end
      wide_ff <= wide_in;
   end

   b2r_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .can_take  (can_take),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (out_data)
   );

   assign rsp_bus.pixel_rgb565 = out_data.pixel_rgb565;
   assign rsp_bus.column       = out_data.column;
   assign rsp_bus.row          = out_data.row;
   assign rsp_bus.status       = out_data.status;
   assign rsp_bus.last_pixel   = out_data.last_pixel;

endmodule

// ----- rtl/core/b2r_checker.sv -----
// Port-level checker for the bitmap stream decoder, with its bind statement.
module b2r_checker import b2r_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] pixel_rgb565,
   input logic [7:0]  column,
   input logic [30:0] row,
   input logic [2:0]  status,
   input logic        last_pixel
);

   // An error word carries nothing but its status code.
   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != STAT_PIXEL |->
         pixel_rgb565 == 16'd0 && column == 8'd0 && row == 31'd0 && !last_pixel)
      else $error("error word with nonzero pixel fields");

   // The final-pixel flag only rides on pixel words.
   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_pixel |-> status == STAT_PIXEL)
      else $error("last_pixel set on an error word");

   // Reset empties the result buffer.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present right after reset");

   // Input is held off only while a result word is waiting to be taken.
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(pixel_rgb565) && $stable(column) && $stable(row) &&
         $stable(status) && $stable(last_pixel))
      else $error("stalled result word changed");

endmodule

bind bmp24_to_rgb565_stream_decoder b2r_checker u_b2r_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .pixel_rgb565 (rsp_bus.pixel_rgb565),
   .column       (rsp_bus.column),
   .row          (rsp_bus.row),
   .status       (rsp_bus.status),
   .last_pixel   (rsp_bus.last_pixel)
);
